@@ hw/rtl/i2ra_pkg.sv @@
// ----------------------------------------------------------------------------
// i2ra_pkg
// Shared types and constants for the integer to radix ASCII converter:
// channel payloads, controller/datapath command and status, FSM states.
// ----------------------------------------------------------------------------
package i2ra_pkg;

   // Input item: signed word and the radix of the text
   typedef struct packed {
      logic signed [31:0] value;
      logic [4:0]         base;
   } req_type;

   // Result item: one ASCII character of the text
   typedef struct packed {
      logic [6:0] character;
      logic       last;
      logic       bad_base;
   } rsp_type;

   // Legal radix range
   localparam logic [4:0] BASE_MIN = 5'd2;
   localparam logic [4:0] BASE_MAX = 5'd16;

   // ASCII codes
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_UPPER = 7'h41;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_NULL  = 7'h00;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_BAD,
      ST_SIGN,
      ST_DIGIT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // capture a new item
      logic div_step;    // one chunk of the divide-by-base
      logic emit_bad;    // send the bad-base result
      logic emit_sign;   // send the minus sign
      logic emit_digit;  // pop one digit and send it
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_bad;     // incoming base is out of range
      logic negative;    // captured value is negative
      logic div_last;    // current chunk finishes a digit
      logic quot_zero;   // quotient of the current digit is zero
      logic out_free;    // output register can take a result
      logic digit_last;  // one digit left in the buffer
   } sts_type;

   // Digit value to ASCII, 0-9 then A-F
   function automatic logic [6:0] digit_char(input logic [3:0] d);
      logic [6:0] code;
      if (d < 4'd10) begin
         code = CHAR_ZERO + {3'b000, d};
      end else begin
         code = CHAR_UPPER + {3'b000, d} - 7'd10;
      end
      return code;
   endfunction

endpackage

@@ hw/rtl/i2ra_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2ra_ctrl
// Sequencer: accepts an item, sends the bad-base result or runs the digit
// divide loop, then sends sign and digits through the output register.
// ----------------------------------------------------------------------------
module i2ra_ctrl
   import i2ra_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.req_bad ? ST_BAD : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last && sts.quot_zero) begin
               state_in = sts.negative ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_BAD: begin
            if (sts.out_free) begin
               cmd.emit_bad = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (sts.out_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.digit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/i2ra_dpath.sv @@
// ----------------------------------------------------------------------------
// i2ra_dpath
// Datapath: magnitude register, chunked divide-by-base unit (8 quotient bits
// per cycle), digit stack and the output register.
// ----------------------------------------------------------------------------
module i2ra_dpath
   import i2ra_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int DIV_BITS = 8;
   localparam int NCHUNK   = (WORD_BITS + DIV_BITS - 1) / DIV_BITS;
   localparam int PAD_BITS = NCHUNK * DIV_BITS;
   localparam int CHUNK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int CNT_W    = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] word;
   logic [WORD_BITS-1:0] mag_abs;

   logic [PAD_BITS-1:0]  mag_ff, mag_in;
   logic [PAD_BITS-1:0]  quot_ff, quot_in;
   logic [PAD_BITS-1:0]  quot_full;
   logic [3:0]           rem_ff, rem_in;
   logic [3:0]           rem_next;
   logic [DIV_BITS-1:0]  qbits;
   logic [CHUNK_W-1:0]   chunk_ff, chunk_in;
   logic [4:0]           base_ff, base_in;
   logic                 neg_ff, neg_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [3:0]           stack_ff [WORD_BITS];
   logic [3:0]           stack_in [WORD_BITS];
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Input word at WORD_BITS, sign extended when wider than the port
   generate
      if (WORD_BITS <= 32) begin : g_narrow
         assign word = req_data.value[WORD_BITS-1:0];
      end else begin : g_wide
         assign word = {{(WORD_BITS-32){req_data.value[31]}}, req_data.value};
      end
   endgenerate

   assign mag_abs = word[WORD_BITS-1] ? (~word + 1'b1) : word;

   // One chunk of restoring division, MSB first
   always_comb begin : div_chunk
      logic [4:0] trial;
      logic [3:0] r;
      r = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {r, mag_ff[PAD_BITS-1-i]};
         if (trial >= base_ff) begin
            trial                = trial - base_ff;
            qbits[DIV_BITS-1-i] = 1'b1;
         end else begin
            qbits[DIV_BITS-1-i] = 1'b0;
         end
         r = trial[3:0];
      end
      rem_next = r;
   end

   assign quot_full = PAD_BITS'({quot_ff, qbits});

   // Status to the controller
   always_comb begin
      sts.req_bad    = (req_data.base < BASE_MIN) || (req_data.base > BASE_MAX);
      sts.negative   = neg_ff;
      sts.div_last   = (chunk_ff == '0);
      sts.quot_zero  = (quot_full == '0);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
      sts.digit_last = (cnt_ff == CNT_W'(1));
   end

   // Next-state logic of the datapath registers
   always_comb begin
      mag_in       = mag_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      stack_in     = stack_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         base_in  = req_data.base;
         neg_in   = word[WORD_BITS-1];
         mag_in   = PAD_BITS'(mag_abs);
         quot_in  = '0;
         rem_in   = '0;
         chunk_in = CHUNK_W'(NCHUNK - 1);
         cnt_in   = '0;
      end

      if (cmd.div_step) begin
         if (chunk_ff == '0) begin
            // digit complete: push remainder, quotient becomes the magnitude
            stack_in[0] = rem_next;
            for (int i = 1; i < WORD_BITS; i++) begin
               stack_in[i] = stack_ff[i-1];
            end
            cnt_in   = cnt_ff + 1'b1;
            mag_in   = quot_full;
            quot_in  = '0;
            rem_in   = '0;
            chunk_in = CHUNK_W'(NCHUNK - 1);
         end else begin
            mag_in   = mag_ff << DIV_BITS;
            quot_in  = quot_full;
            rem_in   = rem_next;
            chunk_in = chunk_ff - 1'b1;
         end
      end

      if (cmd.emit_bad) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = CHAR_NULL;
         rsp_data_in.last      = 1'b1;
         rsp_data_in.bad_base  = 1'b1;
      end

      if (cmd.emit_sign) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = CHAR_MINUS;
         rsp_data_in.last      = 1'b0;
         rsp_data_in.bad_base  = 1'b0;
      end

      if (cmd.emit_digit) begin
         // top of stack is the most significant remaining digit
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = digit_char(stack_ff[0]);
         rsp_data_in.last      = (cnt_ff == CNT_W'(1));
         rsp_data_in.bad_base  = 1'b0;
         for (int i = 0; i < WORD_BITS - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      chunk_ff    <= chunk_in;
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      stack_ff    <= stack_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/integer_to_radix_ascii_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top
// Converts a signed word to its ASCII text in base 2 to 16, one character
// per transfer, most significant first, with a leading '-' when negative.
//
// Usage:
//  - req channel: one transfer carries value and base. req_ready is high only
//    while the block is idle; one item is worked on at a time.
//  - rsp channel: one transfer per character; last marks the final one. A
//    base outside 2 to 16 gives a single transfer with character 0, last and
//    bad_base set.
//  - Sequence: the divide unit forms 8 quotient bits per cycle, working
//    through the magnitude chunk by chunk for each digit. An item is
//    accepted, divided digit by digit, then sent one character at a time
//    (sign included), each character waiting for the output register to be
//    free. The next item is taken in the cycle after the last emit.
//  - The output register holds a character while the receiver stalls; the
//    sequencer waits, nothing is lost. The next item is accepted while the
//    final character still waits in the output register.
//  - Reset (synchronous) returns to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_top
   import i2ra_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   i2ra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Divider, digit stack and output register
   i2ra_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
